// ===== hw/rtl/bb3_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the reciprocal table of the 3x3 RGB box blur.
// No dependencies; every other file of the block imports this package.

package bb3_pkg;

    // Line store depth used when the top level is not overridden.
    localparam int MAX_WIDTH_DEFAULT = 1024;

    // Configuration registers.
    localparam int FW_W = 11;
    localparam int FH_W = 16;
    localparam logic [FW_W-1:0] FRAME_WIDTH_RESET  = 11'd1024;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = 16'd768;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // Item codes.
    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_DRAIN = 1'b1;

    // Datapath widths.
    localparam int CH_W        = 8;
    localparam int ROW_W       = FH_W + 1;   // the drain position runs to height + 1
    localparam int SUM_W       = 12;         // nine 8-bit values
    localparam int VAL_W       = SUM_W + 1;  // 2 * sum + count
    localparam int NB_W        = 4;          // neighbor count, up to nine
    localparam int RECIP_W     = 20;
    localparam int RECIP_SHIFT = 20;
    localparam int PROD_W      = VAL_W + RECIP_W;

    // Output queue.
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = 3;
    localparam int FIFO_CNT_W = 4;

    typedef struct packed {
        logic            func;
        logic [CH_W-1:0] in_red;
        logic [CH_W-1:0] in_green;
        logic [CH_W-1:0] in_blue;
    } t_pix_in;

    typedef struct packed {
        logic [CH_W-1:0] out_red;
        logic [CH_W-1:0] out_green;
        logic [CH_W-1:0] out_blue;
        logic            out_last;
    } t_pix_out;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_rgb;

    // One line store entry: the pixel two rows up and the pixel one row up.
    typedef struct packed {
        t_rgb older;
        t_rgb newer;
    } t_line;

    // Per-item control that follows the window: emit flag, frame end flag
    // and which rows and columns of the 3x3 neighborhood lie in the frame.
    typedef struct packed {
        logic emit;
        logic last;
        logic row_top;
        logic row_mid;
        logic row_bot;
        logic col_left;
        logic col_right;
    } t_tap_ctl;

    // Rounded-mean operands handed to the divide stage.
    typedef struct packed {
        logic [VAL_W-1:0]   v_red;
        logic [VAL_W-1:0]   v_green;
        logic [VAL_W-1:0]   v_blue;
        logic [RECIP_W-1:0] recip;
        logic               last;
    } t_div_in;

    // ceil(2^20 / (2 * n)); floor((2*sum + n) * m / 2^20) is then exact for
    // every sum of n 8-bit values.
    function automatic logic [RECIP_W-1:0] bb3_recip(input logic [NB_W-1:0] n);
        logic [RECIP_W-1:0] m;
        case (n)
            4'd1:    m = 20'd524288;
            4'd2:    m = 20'd262144;
            4'd3:    m = 20'd174763;
            4'd4:    m = 20'd131072;
            4'd5:    m = 20'd104858;
            4'd6:    m = 20'd87382;
            4'd7:    m = 20'd74899;
            4'd8:    m = 20'd65536;
            4'd9:    m = 20'd58255;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

// ===== hw/rtl/bb3_ctrl.sv =====
`timescale 1ns / 1ps
// Configuration registers, frame position counters and neighborhood decode.
// Depends on bb3_pkg.

module bb3_ctrl
    import bb3_pkg::*;
#(
    parameter  int MAX_WIDTH = MAX_WIDTH_DEFAULT,
    localparam int XW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1,
    localparam int CW = (XW + 1 > FW_W) ? XW + 1 : FW_W
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               i_accept,
    input  t_pix_in            i_in_data,
    output logic               o_rd_en,
    output logic [XW-1:0]      o_rd_addr,
    output logic               o_s1_valid,
    output logic [XW-1:0]      o_s1_x,
    output t_rgb               o_s1_pix,
    output t_tap_ctl           o_s1_ctl
);

    logic [FW_W-1:0]  r_frame_width;
    logic [FH_W-1:0]  r_frame_height;
    logic [XW-1:0]    r_col;
    logic [FH_W-1:0]  r_row;
    logic [CW-1:0]    r_drain;
    logic             r_s1_valid;
    logic [XW-1:0]    r_s1_x;
    t_rgb             r_s1_pix;
    t_tap_ctl         r_s1_ctl;

    logic [CW-1:0]    w;
    logic [FH_W-1:0]  h;
    logic             cfg_wr;
    logic             reg_idx;
    logic             draining;
    logic             drain_end;
    logic             act;
    logic             col_wrap;
    logic [XW-1:0]    x;
    logic [ROW_W-1:0] y;
    logic [ROW_W-1:0] cr;
    logic [CW-1:0]    cc;
    t_rgb             pix;
    t_tap_ctl         ctl;

    // Frame size in use: width clamped to [2, MAX_WIDTH], height at least 2.
    always_comb begin
        if (r_frame_width < FW_W'(2)) begin
            w = CW'(2);
        end else if (int'(r_frame_width) > MAX_WIDTH) begin
            w = CW'(MAX_WIDTH);
        end else begin
            w = CW'(r_frame_width);
        end
        h = (r_frame_height < FH_W'(2)) ? FH_W'(2) : r_frame_height;
    end

    // Register port.
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[PADDR_W-1];
    assign pready  = 1'b1;

    always_comb begin
        case (reg_idx)
            REG_FRAME_WIDTH:  prdata = PDATA_W'(r_frame_width);
            REG_FRAME_HEIGHT: prdata = PDATA_W'(r_frame_height);
            default:          prdata = '0;
        endcase
    end

    // Position of this item and the part of its neighborhood inside the frame.
    // Once all pixels are in, every item is a drain tick; before that a drain
    // tick does nothing.
    assign draining  = r_row >= h;
    assign drain_end = r_drain >= w;
    assign act       = draining || (i_in_data.func == FUNC_PIXEL);
    assign col_wrap  = (CW'(r_col) + CW'(1)) >= w;

    always_comb begin
        pix = '0;
        if (draining) begin
            if (drain_end) begin
                x = '0;
                y = ROW_W'(h) + ROW_W'(1);
            end else begin
                x = r_drain[XW-1:0];
                y = ROW_W'(h);
            end
        end else begin
            x         = r_col;
            y         = ROW_W'(r_row);
            pix.red   = i_in_data.in_red;
            pix.green = i_in_data.in_green;
            pix.blue  = i_in_data.in_blue;
        end

        // The window center trails the input by one row and one column.
        if (x != '0) begin
            ctl.emit = y >= ROW_W'(1);
            cr       = y - ROW_W'(1);
            cc       = CW'(x) - CW'(1);
        end else begin
            ctl.emit = y >= ROW_W'(2);
            cr       = y - ROW_W'(2);
            cc       = w - CW'(1);
        end
        ctl.last      = draining && drain_end;
        ctl.row_top   = cr >= ROW_W'(1);
        ctl.row_mid   = cr < ROW_W'(h);
        ctl.row_bot   = (cr + ROW_W'(1)) < ROW_W'(h);
        ctl.col_left  = cc >= CW'(1);
        ctl.col_right = (cc + CW'(1)) < w;
    end

    assign o_rd_en   = i_accept && act;
    assign o_rd_addr = x;

    // Configuration and counters; a register write restarts the frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RESET;
            r_frame_height <= FRAME_HEIGHT_RESET;
            r_col          <= '0;
            r_row          <= '0;
            r_drain        <= '0;
            r_s1_valid     <= 1'b0;
        end else begin
            r_s1_valid <= i_accept && act;
            if (cfg_wr) begin
                case (reg_idx)
                    REG_FRAME_WIDTH:  r_frame_width  <= pwdata[FW_W-1:0];
                    REG_FRAME_HEIGHT: r_frame_height <= pwdata[FH_W-1:0];
                    default: ;
                endcase
                r_col   <= '0;
                r_row   <= '0;
                r_drain <= '0;
            end else if (i_accept && act) begin
                if (ctl.last) begin
                    r_col   <= '0;
                    r_row   <= '0;
                    r_drain <= '0;
                end else if (draining) begin
                    r_drain <= r_drain + CW'(1);
                end else if (col_wrap) begin
                    r_col <= '0;
                    r_row <= r_row + FH_W'(1);
                end else begin
                    r_col <= r_col + XW'(1);
                end
            end
        end
    end

    // Item payload for the window stage.
    always_ff @(posedge i_clk) begin
        if (i_accept && act) begin
            r_s1_x   <= x;
            r_s1_pix <= pix;
            r_s1_ctl <= ctl;
        end
    end

    assign o_s1_valid = r_s1_valid;
    assign o_s1_x     = r_s1_x;
    assign o_s1_pix   = r_s1_pix;
    assign o_s1_ctl   = r_s1_ctl;

    // While pixels are still expected the column stays inside the row.
    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row < h) |-> (CW'(r_col) < w))
        else $error("column counter left the row");

    // The last pixel of a frame wraps the column back to zero.
    a_col_zero_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row >= h) |-> (r_col == '0))
        else $error("column counter not cleared at frame end");

    // Drain ticks only count after the last pixel, and never past the width.
    a_drain_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_drain != '0) |-> ((r_row == h) && (r_drain <= w)))
        else $error("drain counter out of step with the frame");

endmodule

// ===== hw/rtl/bb3_line_mem.sv =====
`timescale 1ns / 1ps
// Two-row line store: one entry per column holds the pixels of the two rows above.
// Depends on bb3_pkg.

module bb3_line_mem
    import bb3_pkg::*;
#(
    parameter  int MAX_WIDTH = MAX_WIDTH_DEFAULT,
    localparam int XW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd_en,
    input  logic [XW-1:0] i_rd_addr,
    input  logic          i_wr_en,
    input  logic [XW-1:0] i_wr_addr,
    input  t_line         i_wr_data,
    output t_line         o_rd_data
);

    t_line r_mem [MAX_WIDTH];
    t_line r_rd_data;
    t_line r_fwd_data;
    logic  r_fwd_hit;

    // One write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // A read of the entry being written in the same cycle takes the new data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else begin
            r_fwd_hit <= i_rd_en && i_wr_en && (i_rd_addr == i_wr_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_data <= i_wr_data;
    end

    assign o_rd_data = r_fwd_hit ? r_fwd_data : r_rd_data;

endmodule

// ===== hw/rtl/bb3_window.sv =====
`timescale 1ns / 1ps
// 3x3 window registers and the masked channel sums of the neighborhood.
// Depends on bb3_pkg.

module bb3_window
    import bb3_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s1_valid,
    input  t_tap_ctl i_s1_ctl,
    input  t_rgb     i_col_top,
    input  t_rgb     i_col_mid,
    input  t_rgb     i_col_bot,
    output logic     o_s2_valid,
    output logic     o_s3_valid,
    output t_div_in  o_s3_data
);

    t_rgb             r_win [3][3];
    logic             r_s2_valid;
    t_tap_ctl         r_s2_ctl;
    logic             r_s3_valid;
    t_div_in          r_s3_data;

    logic [2:0]       row_ok;
    logic [2:0]       col_ok;
    logic [SUM_W-1:0] sum_r;
    logic [SUM_W-1:0] sum_g;
    logic [SUM_W-1:0] sum_b;
    logic [NB_W-1:0]  nb;
    t_div_in          s3_next;

    // Shift the window one column left and load the new column on the right.
    always_ff @(posedge i_clk) begin
        if (i_s1_valid) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i][0] <= r_win[i][1];
                r_win[i][1] <= r_win[i][2];
            end
            r_win[0][2] <= i_col_top;
            r_win[1][2] <= i_col_mid;
            r_win[2][2] <= i_col_bot;
        end
    end

    // Sum the in-frame neighbors and count them.
    always_comb begin
        row_ok = {r_s2_ctl.row_bot, r_s2_ctl.row_mid, r_s2_ctl.row_top};
        col_ok = {r_s2_ctl.col_right, 1'b1, r_s2_ctl.col_left};
        sum_r  = '0;
        sum_g  = '0;
        sum_b  = '0;
        nb     = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                if (row_ok[i] && col_ok[j]) begin
                    sum_r = sum_r + SUM_W'(r_win[i][j].red);
                    sum_g = sum_g + SUM_W'(r_win[i][j].green);
                    sum_b = sum_b + SUM_W'(r_win[i][j].blue);
                    nb    = nb + NB_W'(1);
                end
            end
        end
        // Round half up: (2*sum + n) / (2*n).
        s3_next.v_red   = {sum_r, 1'b0} + VAL_W'(nb);
        s3_next.v_green = {sum_g, 1'b0} + VAL_W'(nb);
        s3_next.v_blue  = {sum_b, 1'b0} + VAL_W'(nb);
        s3_next.recip   = bb3_recip(nb);
        s3_next.last    = r_s2_ctl.last;
    end

    // Stage valids; only items that give a result travel on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            r_s2_valid <= i_s1_valid && i_s1_ctl.emit;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s1_valid) begin
            r_s2_ctl <= i_s1_ctl;
        end
        if (r_s2_valid) begin
            r_s3_data <= s3_next;
        end
    end

    assign o_s2_valid = r_s2_valid;
    assign o_s3_valid = r_s3_valid;
    assign o_s3_data  = r_s3_data;

    // The center row of an emitted pixel is always inside the frame.
    a_center_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid |-> r_s2_ctl.row_mid)
        else $error("emitted pixel with center row outside the frame");

    // With at least two rows, one of the outer rows is in the frame.
    a_two_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid |-> (r_s2_ctl.row_top || r_s2_ctl.row_bot))
        else $error("emitted pixel sees a single row");

    // With at least two columns, one of the outer columns is in the frame.
    a_two_cols: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid |-> (r_s2_ctl.col_left || r_s2_ctl.col_right))
        else $error("emitted pixel sees a single column");

endmodule

// ===== hw/rtl/bb3_divide.sv =====
`timescale 1ns / 1ps
// Rounded mean by multiplication with the reciprocal of twice the neighbor count.
// Depends on bb3_pkg.

module bb3_divide
    import bb3_pkg::*;
(
    input  logic     i_valid,
    input  t_div_in  i_data,
    output logic     o_push,
    output t_pix_out o_data
);

    logic [PROD_W-1:0] prod_r;
    logic [PROD_W-1:0] prod_g;
    logic [PROD_W-1:0] prod_b;

    // One multiplier per channel; the quotient sits above the fraction bits.
    assign prod_r = PROD_W'(i_data.v_red)   * PROD_W'(i_data.recip);
    assign prod_g = PROD_W'(i_data.v_green) * PROD_W'(i_data.recip);
    assign prod_b = PROD_W'(i_data.v_blue)  * PROD_W'(i_data.recip);

    assign o_data.out_red   = prod_r[RECIP_SHIFT +: CH_W];
    assign o_data.out_green = prod_g[RECIP_SHIFT +: CH_W];
    assign o_data.out_blue  = prod_b[RECIP_SHIFT +: CH_W];
    assign o_data.out_last  = i_data.last;
    assign o_push           = i_valid;

endmodule

// ===== hw/rtl/bb3_out_fifo.sv =====
`timescale 1ns / 1ps
// Eight-entry output queue that decouples the result channel from the pipeline.
// Depends on bb3_pkg.

module bb3_out_fifo
    import bb3_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  t_pix_out              i_data,
    output logic                  o_valid,
    output t_pix_out              o_data,
    input  logic                  i_ready,
    output logic [FIFO_CNT_W-1:0] o_count
);

    t_pix_out              r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;
    logic                  pop;

    assign pop = (r_count != '0) && i_ready;

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_PTR_W'(1);
            end
            r_count <= r_count + FIFO_CNT_W'(i_push) - FIFO_CNT_W'(pop);
        end
    end

    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

    // The input credit check must keep a free entry for every result in flight.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> ((r_count < FIFO_CNT_W'(FIFO_DEPTH)) || pop))
        else $error("output queue overflow");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("output queue count out of range");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("output queue pointers disagree with count");

endmodule

// ===== hw/rtl/box_blur_3x3_rgb_unit.sv =====
`timescale 1ns / 1ps
// Top level of the streaming 3x3 RGB box blur.
// Depends on bb3_pkg, bb3_ctrl, bb3_line_mem, bb3_window, bb3_divide, bb3_out_fifo.
//
// Channel  Handshake                    Payload
// input    i_in_valid / o_in_ready      t_pix_in  : func, in_red, in_green, in_blue
// output   o_out_valid / i_out_ready    t_pix_out : out_red, out_green, out_blue, out_last
// config   psel, penable, pwrite/pready frame_width at 0x0, frame_height at 0x4
//
// One item per cycle unless the input stalls; one line store read and one write per item.
// The result for item k is completed by item k+W+1 and passes s1, s2, s3 into the queue.
// Reset clears counters, config and valids; the line store is not cleared and needs no pass.
// An eight-entry output queue holds results; the input stalls only when results in
// flight plus queued results reach eight.

module box_blur_3x3_rgb_unit
    import bb3_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_pix_in            i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_pix_out           o_out_data
);

    localparam int XW    = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int OCC_W = FIFO_CNT_W + 1;

    logic                  accept;
    logic                  rd_en;
    logic [XW-1:0]         rd_addr;
    t_line                 rd_data;
    t_line                 wr_data;
    logic                  s1_valid;
    logic [XW-1:0]         s1_x;
    t_rgb                  s1_pix;
    t_tap_ctl              s1_ctl;
    logic                  s2_valid;
    logic                  s3_valid;
    t_div_in               s3_data;
    logic                  push;
    t_pix_out              push_data;
    logic [FIFO_CNT_W-1:0] fifo_count;
    logic [OCC_W-1:0]      occupancy;

    // Accept only while the output queue has room for every result in flight.
    assign occupancy = OCC_W'(s1_valid && s1_ctl.emit) + OCC_W'(s2_valid)
                     + OCC_W'(s3_valid) + OCC_W'(fifo_count);
    assign o_in_ready = occupancy < OCC_W'(FIFO_DEPTH);
    assign accept     = i_in_valid && o_in_ready;

    bb3_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .i_accept   (accept),
        .i_in_data  (i_in_data),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .o_s1_valid (s1_valid),
        .o_s1_x     (s1_x),
        .o_s1_pix   (s1_pix),
        .o_s1_ctl   (s1_ctl)
    );

    // The newer row moves to the older slot and the new pixel becomes the newer row.
    assign wr_data = '{older: rd_data.newer, newer: s1_pix};

    bb3_line_mem #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .i_wr_en   (s1_valid),
        .i_wr_addr (s1_x),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

    bb3_window u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s1_valid (s1_valid),
        .i_s1_ctl   (s1_ctl),
        .i_col_top  (rd_data.older),
        .i_col_mid  (rd_data.newer),
        .i_col_bot  (s1_pix),
        .o_s2_valid (s2_valid),
        .o_s3_valid (s3_valid),
        .o_s3_data  (s3_data)
    );

    bb3_divide u_divide (
        .i_valid (s3_valid),
        .i_data  (s3_data),
        .o_push  (push),
        .o_data  (push_data)
    );

    bb3_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .i_ready (i_out_ready),
        .o_count (fifo_count)
    );

endmodule
